// File: src/rmdf_pkg.sv
// ----------------------------------------------------------------------------
// rmdf_pkg - shared types and constants for the row median dropout fill
// Sizes, register map, control state codes and the cell control bundle.
// ----------------------------------------------------------------------------
package rmdf_pkg;

	// default sizing
	localparam int MAX_ROW_DEF     = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int VALUE_BITS = 16;
	localparam int THR_BITS   = 16;

	// register port
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'b0;
	localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd1966;   // 0.03 in Q0.16

	// control states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MEDIAN,
		ST_EMIT
	} state_t;

	// per-cycle command to the sort chain
	typedef struct packed {
		logic ins;   // insert the broadcast sample
		logic shd;   // shift every cell one step toward cell 0
	} cell_ctl_t;

endpackage

// File: src/row_median_dropout_fill_core.sv
// ----------------------------------------------------------------------------
// row_median_dropout_fill_core - per-row median fill of low dropout samples
// Buffers a row, sorts it in a cell chain, then replays it with samples that
// are below both the row mean and the threshold replaced by the row median.
// ----------------------------------------------------------------------------
// Phases for a row of n stored samples:
//   load: one sample item per cycle, sorted on the fly in the chain.
//   median: the chain shifts down with the input stalled.
//   emit: results come from the prefetched raw entries, one result per cycle
//   while result_stall is low.
// Reset clears the FSM, count, sum, overflow flag and output valid, and
// sets the threshold register (thr_q) to 1966; sample stores need no clearing.
// ----------------------------------------------------------------------------
module row_median_dropout_fill_core #(
	parameter int MAX_ROW     = rmdf_pkg::MAX_ROW_DEF,
	parameter int SAMPLE_BITS = rmdf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rmdf_pkg::PADDR_W-1:0]   paddr,
	input  logic [rmdf_pkg::PDATA_W-1:0]   pwdata,
	output logic [rmdf_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// sample channel
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [rmdf_pkg::VALUE_BITS-1:0] sample,
	input  logic                           row_end,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [rmdf_pkg::VALUE_BITS-1:0] value,
	output logic                           last,
	output logic                           overflow
);

	localparam int CNT_W  = $clog2(MAX_ROW + 1);
	localparam int IDX_W  = $clog2(MAX_ROW);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_ROW);
	localparam int PROD_W = SAMPLE_BITS + CNT_W;
	localparam int CMP_W  = (SAMPLE_BITS > rmdf_pkg::THR_BITS) ?
	                        SAMPLE_BITS : rmdf_pkg::THR_BITS;

	// ---------------------------------------------------------------
	// register port: single threshold register, zero wait states
	// ---------------------------------------------------------------
	logic [rmdf_pkg::THR_BITS-1:0]  thr_q;
	logic [rmdf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (reg_idx == rmdf_pkg::REG_THRESH) begin
			prdata = rmdf_pkg::PDATA_W'(thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rmdf_pkg::THR_RESET;
		end else if (reg_wr && reg_idx == rmdf_pkg::REG_THRESH) begin
			thr_q <= pwdata[rmdf_pkg::THR_BITS-1:0];
		end
	end

	// ---------------------------------------------------------------
	// row state
	// ---------------------------------------------------------------
	rmdf_pkg::state_t       st_q, st_d;
	logic [CNT_W-1:0]       cnt_q;      // stored samples this row
	logic [SUM_W-1:0]       sum_q;      // running sum of stored samples
	logic                   ovf_q;      // a sample was dropped this row
	logic [CNT_W-1:0]       shift_q;    // chain shifts left before median
	logic [IDX_W-1:0]       k_q;        // index of the item in rdata_q
	logic [SAMPLE_BITS-1:0] rdata_q;    // registered raw row read

	logic [SAMPLE_BITS-1:0] raw_mem [MAX_ROW];

	logic [SAMPLE_BITS-1:0] s_in;
	logic                   in_acc;
	logic                   room;
	logic                   store;
	logic                   close;
	logic [CNT_W-1:0]       n_inc;
	logic                   out_free;
	logic                   emit;
	logic                   mem_re;
	logic [IDX_W-1:0]       raddr;
	logic                   is_last;
	rmdf_pkg::cell_ctl_t    ctl;
	logic [SAMPLE_BITS-1:0] median;

	// sample is taken modulo 2^SAMPLE_BITS
	assign s_in   = SAMPLE_BITS'(sample);
	assign in_acc = sample_valid && !sample_stall;
	assign room   = cnt_q < CNT_W'(MAX_ROW);
	assign store  = in_acc && room;
	assign close  = in_acc && row_end;
	assign n_inc  = cnt_q + CNT_W'(1);

	// output register is free when empty or being taken this cycle
	assign out_free = !result_valid || !result_stall;
	assign is_last  = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;

	// ---------------------------------------------------------------
	// control FSM
	//   LOAD:   accept samples, insert into chain, write raw row
	//   MEDIAN: shift chain n/2 times so the median lands in cell 0,
	//           then prefetch raw entry 0
	//   EMIT:   one corrected item per free output slot
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rmdf_pkg::ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d         = st_q;
		sample_stall = 1'b1;
		ctl          = '0;
		mem_re       = 1'b0;
		raddr        = k_q + IDX_W'(1);
		emit         = 1'b0;
		unique case (st_q)
			rmdf_pkg::ST_LOAD: begin
				sample_stall = 1'b0;
				ctl.ins      = store;
				if (close) begin
					st_d = rmdf_pkg::ST_MEDIAN;
				end
			end
			rmdf_pkg::ST_MEDIAN: begin
				if (shift_q != '0) begin
					ctl.shd = 1'b1;
				end else begin
					mem_re = 1'b1;
					raddr  = '0;
					st_d   = rmdf_pkg::ST_EMIT;
				end
			end
			rmdf_pkg::ST_EMIT: begin
				if (out_free) begin
					emit   = 1'b1;
					mem_re = 1'b1;      // fetch next entry behind this one
					if (is_last) begin
						st_d = rmdf_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				st_d = rmdf_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			shift_q <= '0;
			k_q     <= '0;
		end else begin
			if (store) begin
				cnt_q <= n_inc;
				sum_q <= sum_q + SUM_W'(s_in);
			end
			if (in_acc && !room) begin
				ovf_q <= 1'b1;
			end
			// median rank is n/2 of the row including this last sample if it is stored
			if (close) begin
				shift_q <= (store ? n_inc : cnt_q) >> 1;
			end
			if (ctl.shd) begin
				shift_q <= shift_q - CNT_W'(1);
			end
			if (mem_re && st_q == rmdf_pkg::ST_MEDIAN) begin
				k_q <= '0;
			end
			if (emit) begin
				k_q <= k_q + IDX_W'(1);
				if (is_last) begin
					cnt_q <= '0;
					sum_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// raw row buffer: one write port, one registered read port
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (store) begin
			raw_mem[cnt_q[IDX_W-1:0]] <= s_in;
		end
		if (mem_re) begin
			rdata_q <= raw_mem[raddr];
		end
	end

	// ---------------------------------------------------------------
	// sort chain, median ends up in the head cell
	// ---------------------------------------------------------------
	rmdf_sort_chain #(
		.MAX_ROW     (MAX_ROW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.CNT_W       (CNT_W)
	) u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.count (cnt_q),
		.din   (s_in),
		.head  (median)
	);

	// ---------------------------------------------------------------
	// fill decision: below mean (v*n < sum) and strictly below threshold
	// ---------------------------------------------------------------
	logic low_mean;
	logic low_thr;
	logic [SAMPLE_BITS-1:0] fixed_v;

	assign low_mean = (PROD_W'(rdata_q) * PROD_W'(cnt_q)) < PROD_W'(sum_q);
	assign low_thr  = CMP_W'(rdata_q) < CMP_W'(thr_q);
	assign fixed_v  = (low_mean && low_thr) ? median : rdata_q;

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	logic                            res_valid_q;
	logic [rmdf_pkg::VALUE_BITS-1:0] value_q;
	logic                            last_q;
	logic                            ovf_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q   <= rmdf_pkg::VALUE_BITS'(fixed_v);
			last_q    <= is_last;
			ovf_out_q <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign last         = last_q;
	assign overflow     = ovf_out_q;

endmodule

// File: src/rmdf_cell.sv
// ----------------------------------------------------------------------------
// rmdf_cell - one slot of the insertion sort chain
// Holds one sorted sample; on insert it keeps, takes the new sample or takes
// its lower neighbor's value; on shift it takes its upper neighbor's value.
// ----------------------------------------------------------------------------
module rmdf_cell #(
	parameter int W = rmdf_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  rmdf_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic [W-1:0]      din,
	input  logic [W-1:0]      prev_val,
	input  logic              prev_gt,
	input  logic [W-1:0]      next_val,
	output logic [W-1:0]      val,
	output logic              gt
);

	logic [W-1:0] val_q;

	assign val = val_q;
	// occupied and strictly larger than the incoming sample: it moves up
	assign gt  = occ && (val_q > din);

	always_ff @(posedge clk) begin
		if (ctl.shd) begin
			val_q <= next_val;
		end else if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || !occ) begin
				val_q <= din;
			end
		end
	end

endmodule

// File: src/rmdf_sort_chain.sv
// ----------------------------------------------------------------------------
// rmdf_sort_chain - row of sort cells, ascending from cell 0
// Inserts one sample per cycle; shifts down to bring a chosen rank to cell 0.
// ----------------------------------------------------------------------------
module rmdf_sort_chain #(
	parameter int MAX_ROW     = rmdf_pkg::MAX_ROW_DEF,
	parameter int SAMPLE_BITS = rmdf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = $clog2(MAX_ROW + 1)
) (
	input  logic                   clk,
	input  rmdf_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]       count,
	input  logic [SAMPLE_BITS-1:0] din,
	output logic [SAMPLE_BITS-1:0] head
);

	logic [SAMPLE_BITS-1:0] vals [MAX_ROW];
	logic                   gts  [MAX_ROW];

	assign head = vals[0];

	for (genvar i = 0; i < MAX_ROW; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] pv;
		logic                   pg;
		logic [SAMPLE_BITS-1:0] nv;

		if (i == 0) begin : g_first
			assign pv = vals[0];
			assign pg = 1'b0;
		end else begin : g_mid
			assign pv = vals[i-1];
			assign pg = gts[i-1];
		end

		if (i == MAX_ROW - 1) begin : g_last
			assign nv = vals[i];
		end else begin : g_up
			assign nv = vals[i+1];
		end

		rmdf_cell #(
			.W(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (count > CNT_W'(i)),
			.din      (din),
			.prev_val (pv),
			.prev_gt  (pg),
			.next_val (nv),
			.val      (vals[i]),
			.gt       (gts[i])
		);
	end

endmodule

// File: src/rmdf_checker.sv
// ----------------------------------------------------------------------------
// rmdf_checker - port-level checks for the row median dropout fill core
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module rmdf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            sample_valid,
	input logic                            sample_stall,
	input logic                            row_end,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [rmdf_pkg::VALUE_BITS-1:0] value,
	input logic                            last,
	input logic                            overflow
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(value) && $stable(last) && $stable(overflow))
		else $error("result changed while stalled");

	// a closing item stops intake until the row is replayed
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && row_end |=> sample_stall)
		else $error("intake open right after row end");

	// mid-row results only while intake is held off
	a_emit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> sample_stall)
		else $error("intake open during row replay");

	// overflow flag is constant across one row
	a_ovf_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=>
			!result_valid || $stable(overflow))
		else $error("overflow flag changed within a row");

endmodule

bind row_median_dropout_fill_core rmdf_checker u_rmdf_checker (.*);

// File: dv/row_median_dropout_fill_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_median_dropout_fill_checker - row fill predictor and result scoreboard
// Watches the register port, the sample channel and the result channel,
// rebuilds each row, predicts the filled row on close and compares results.
// ----------------------------------------------------------------------------
module row_median_dropout_fill_checker #(
	parameter int ROW_CAP = rmdf_pkg::MAX_ROW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rmdf_pkg::PADDR_W-1:0]    paddr,
	input  logic [rmdf_pkg::PDATA_W-1:0]    pwdata,
	input  logic [rmdf_pkg::PDATA_W-1:0]    prdata,
	input  logic                            pready,
	input  logic                            sample_valid,
	input  logic                            sample_stall,
	input  logic [rmdf_pkg::VALUE_BITS-1:0] sample,
	input  logic                            row_end,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [rmdf_pkg::VALUE_BITS-1:0] value,
	input  logic                            last,
	input  logic                            overflow,
	output int                              mismatches,
	output int                              pending,
	output int                              rows_closed,
	output int                              results_seen
);

	typedef struct packed {
		logic [rmdf_pkg::VALUE_BITS-1:0] value;
		logic                            last;
		logic                            overflow;
	} fill_result_t;

	fill_result_t                    filled_q[$];
	logic [rmdf_pkg::VALUE_BITS-1:0] row_raw [ROW_CAP];
	logic [rmdf_pkg::VALUE_BITS-1:0] row_sorted [ROW_CAP];
	logic [rmdf_pkg::THR_BITS-1:0]   thr_level;
	int unsigned                     row_total;
	int                              row_len;
	bit                              row_over;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// store, sort and sum one sample; on close, queue the filled row
	task automatic take_sample(input logic [rmdf_pkg::VALUE_BITS-1:0] s,
			input logic closes);
		int                              pos;
		int unsigned                     v32;
		logic [rmdf_pkg::VALUE_BITS-1:0] med;
		fill_result_t                    r;
		if (row_len < ROW_CAP) begin
			row_raw[row_len] = s;
			pos = row_len;
			while (pos > 0 && row_sorted[pos-1] > s) begin
				row_sorted[pos] = row_sorted[pos-1];
				pos--;
			end
			row_sorted[pos] = s;
			row_total += s;
			row_len++;
		end else begin
			row_over = 1'b1;
		end
		if (closes) begin
			if (row_len > 0) begin
				med = row_sorted[row_len/2];   // upper median for even length
				for (int k = 0; k < row_len; k++) begin
					v32 = row_raw[k];
					r.value    = row_raw[k];
					if (v32 * row_len < row_total && row_raw[k] < thr_level)
						r.value = med;
					r.last     = (k == row_len - 1);
					r.overflow = row_over;
					filled_q.insert(filled_q.size(), r);
				end
				rows_closed++;
			end
			row_total = 0;
			row_len   = 0;
			row_over  = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_level    = rmdf_pkg::THR_RESET;
			row_total    = 0;
			row_len      = 0;
			row_over     = 1'b0;
			filled_q.delete();
			mismatches   = 0;
			pending      = 0;
			rows_closed  = 0;
			results_seen = 0;
		end else begin
			fill_result_t want;
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[rmdf_pkg::PADDR_W-1:2] == rmdf_pkg::REG_THRESH)
						thr_level = pwdata[rmdf_pkg::THR_BITS-1:0];
				end else if (paddr[rmdf_pkg::PADDR_W-1:2] == rmdf_pkg::REG_THRESH &&
						prdata !== {{(rmdf_pkg::PDATA_W-rmdf_pkg::THR_BITS){1'b0}},
						thr_level}) begin
					report_mismatch($sformatf("threshold read exp %0d got %0d",
						thr_level, prdata));
				end
			end
			if (sample_valid && !sample_stall)
				take_sample(sample, row_end);
			if (result_valid && !result_stall) begin
				results_seen++;
				if (filled_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d last %0b ovf %0b",
						value, last, overflow));
				end else begin
					want = filled_q.pop_front();
					if (value !== want.value || last !== want.last ||
							overflow !== want.overflow)
						report_mismatch($sformatf(
							"value exp %0d got %0d, last exp %0b got %0b, ovf exp %0b got %0b",
							want.value, value, want.last, last, want.overflow, overflow));
				end
			end
			pending = filled_q.size();
		end
	end

endmodule

// File: dv/row_median_dropout_fill_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_median_dropout_fill_core_tb - stimulus and verdict for the row fill core
// Feeds directed and random rows under several thresholds with random idling
// on both channels and one long result hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
module row_median_dropout_fill_core_tb;

	// register addresses: threshold at index 0, index 1 is unmapped
	localparam logic [rmdf_pkg::PADDR_W-1:0] THRESH_ADDR = {rmdf_pkg::REG_THRESH, 2'b00};
	localparam logic [rmdf_pkg::PADDR_W-1:0] SPARE_ADDR  = {~rmdf_pkg::REG_THRESH, 2'b00};

	// long result hold-off, cycles before a config write, tail after drain
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	// no-progress limit: hold-off plus a full-row median pass, several times over
	localparam int WATCHDOG_LIMIT = 2500;

	logic                            clk;
	logic                            arst_n;
	logic                            psel, penable, pwrite;
	logic [rmdf_pkg::PADDR_W-1:0]    paddr;
	logic [rmdf_pkg::PDATA_W-1:0]    pwdata, prdata;
	logic                            pready;
	logic                            sample_valid, sample_stall;
	logic [rmdf_pkg::VALUE_BITS-1:0] sample;
	logic                            row_end;
	logic                            result_valid, result_stall;
	logic [rmdf_pkg::VALUE_BITS-1:0] value;
	logic                            last, overflow;

	int mismatches, pending, rows_closed, results_seen;
	int items_sent;
	bit calm_tail;        // last phase: no idling on either side
	bit long_hold_req;    // receiver should stall once for LONG_HOLD cycles

	row_median_dropout_fill_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.row_end      (row_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.last         (last),
		.overflow     (overflow)
	);

	row_median_dropout_fill_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.row_end      (row_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.last         (last),
		.overflow     (overflow),
		.mismatches   (mismatches),
		.pending      (pending),
		.rows_closed  (rows_closed),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mix of low dropout-like levels, rails and full-range values
	function automatic logic [rmdf_pkg::VALUE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0, 1:    return rmdf_pkg::VALUE_BITS'($urandom_range(0, 4095));
			2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return rmdf_pkg::VALUE_BITS'($urandom);
		endcase
	endfunction

	// one register access: setup cycle, then access until pready
	task automatic apb_access(input logic wr, input logic [rmdf_pkg::PADDR_W-1:0] addr,
			input logic [rmdf_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one item and hold it until taken; maybe idle afterwards.
	// Valid is only lowered by the gap, so a back-to-back item keeps it high.
	task automatic send_sample(input logic [rmdf_pkg::VALUE_BITS-1:0] s_val,
			input logic closes);
		sample_valid <= 1'b1;
		sample       <= s_val;
		row_end      <= closes;
		do @(posedge clk); while (sample_stall !== 1'b0);
		items_sent++;
		if (!calm_tail && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			sample       <= rmdf_pkg::VALUE_BITS'($urandom);     // junk while idle
			row_end      <= 1'($urandom);
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_row(input int len);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(), i == len - 1);
	endtask

	// random rows, mostly short, now and then medium length
	task automatic send_random_rows(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
			                                  : $urandom_range(1, 12);
			if (len > budget - sent)
				len = budget - sent;
			send_row(len);
			sent += len;
		end
	endtask

	// stop offering, wait for every queued result, then let the core go idle
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stall bursts, plus the one long hold-off on request
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && result_valid) begin
				long_hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog: a stretch past the no-progress limit without an accepted item or register access ends the run
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
					(psel && penable))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no progress for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, pending);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		sample_valid  <= 1'b0;
		sample        <= '0;
		row_end       <= 1'b0;
		arst_n        <= 1'b0;
		items_sent    = 0;
		calm_tail     = 1'b0;
		long_hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset threshold must read back as 0.03
		apb_access(1'b0, THRESH_ADDR, '0);

		// directed, default threshold
		send_sample(16'd0, 1'b1);             // single-sample row, nothing below mean
		send_sample(16'd0, 1'b0);             // rails plus a level one under threshold
		send_sample(16'd65535, 1'b0);
		send_sample(16'd1965, 1'b1);
		send_sample(16'd1966, 1'b0);          // even length: upper median is 1966,
		send_sample(16'd65535, 1'b0);         // sample equal to threshold is kept
		send_sample(16'd1965, 1'b0);
		send_sample(16'd0, 1'b1);
		send_sample(16'd10, 1'b0);            // 20 sits exactly on the mean: kept
		send_sample(16'd30, 1'b0);
		send_sample(16'd20, 1'b1);
		send_sample(16'd65535, 1'b0);         // flat row at full scale
		send_sample(16'd65535, 1'b1);
		settle();

		// threshold zero: nothing can be replaced
		apb_access(1'b1, THRESH_ADDR, '0);
		apb_access(1'b0, THRESH_ADDR, '0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd65535, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd1, 1'b1);
		settle();

		// threshold full scale; a write to the unmapped index changes nothing
		apb_access(1'b1, THRESH_ADDR, 32'h0000_FFFF);
		apb_access(1'b1, SPARE_ADDR, $urandom);
		apb_access(1'b0, THRESH_ADDR, '0);
		// over-capacity row closed by a dropped sample, emitted under a long
		// result hold-off while the next rows pile up against the input
		long_hold_req = 1'b1;
		send_row(rmdf_pkg::MAX_ROW_DEF + 1);
		send_random_rows(12);
		settle();

		// random threshold strictly between zero and full scale
		apb_access(1'b1, THRESH_ADDR, $urandom_range(1, 65534));
		apb_access(1'b0, THRESH_ADDR, '0);
		send_random_rows(18);
		settle();

		// low random threshold, no idling on either side
		apb_access(1'b1, THRESH_ADDR, $urandom_range(0, 8191));
		apb_access(1'b0, THRESH_ADDR, '0);
		calm_tail = 1'b1;
		send_random_rows(18);
		sample_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d sample items in %0d rows, %0d results checked",
			items_sent, rows_closed, results_seen);
		$display("thresholds: reset, zero, full scale, two random; one over-capacity row");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/rmdf_pkg.sv
src/rmdf_cell.sv
src/rmdf_sort_chain.sv
src/row_median_dropout_fill_core.sv
src/rmdf_checker.sv
dv/row_median_dropout_fill_checker.sv
dv/row_median_dropout_fill_core_tb.sv
